/* rtl/clcd_pkg.sv */
// Shared constants, codes and types for the two-line character LCD console.
// Used by the line store, the top level and the port checker.
package clcd_pkg;

    localparam int LINE_LENGTH = 16;
    localparam int COL_W       = $clog2(LINE_LENGTH + 1);
    localparam int IDX_W       = $clog2(LINE_LENGTH);

    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic       CMD_SET_ADDR = 1'b1;
    localparam logic [3:0] TAB_MAX      = 4'd8;

    localparam logic [7:0] CHAR_BS = 8'd8;
    localparam logic [7:0] CHAR_HT = 8'd9;
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_FF = 8'd12;
    localparam logic [7:0] CHAR_CR = 8'd13;

    localparam logic [1:0] CFG_FIRST_ADDR  = 2'd0;
    localparam logic [1:0] CFG_SECOND_ADDR = 2'd1;
    localparam logic [1:0] CFG_TAB_WIDTH   = 2'd2;

    typedef struct packed {
        logic             scroll;
        logic             wr_en;
        logic             wr_line;
        logic [IDX_W-1:0] wr_idx;
        logic [7:0]       wr_data;
    } store_wr_t;

endpackage

/* rtl/clcd_line_store.sv */
// Shadow copy of both display lines, reset to spaces, one read port.
// Scroll copies one cell of line two into line one and blanks it.
// Depends on clcd_pkg.
module clcd_line_store
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  clcd_pkg::store_wr_t        wr,
    input  logic                       rd_line,
    input  logic [clcd_pkg::IDX_W-1:0] rd_idx,
    output logic [7:0]                 rd_data
);

    logic [7:0] store_reg [2][clcd_pkg::LINE_LENGTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < 2; l++)
            begin
                for (int i = 0; i < clcd_pkg::LINE_LENGTH; i++)
                begin
                    store_reg[l][i] <= clcd_pkg::SPACE_CHAR;
                end
            end
        end
        else if (wr.scroll)
        begin
            store_reg[0][wr.wr_idx] <= store_reg[1][wr.wr_idx];
            store_reg[1][wr.wr_idx] <= clcd_pkg::SPACE_CHAR;
        end
        else if (wr.wr_en)
        begin
            store_reg[wr.wr_line][wr.wr_idx] <= wr.wr_data;
        end
    end

    assign rd_data = store_reg[rd_line][rd_idx];

endmodule

/* rtl/char_lcd_scrolling_console_unit.sv */
// Top level of the two-line character LCD scrolling console.
// Sequencer, cursor state, configuration registers and output staging.
// Depends on clcd_pkg and clcd_line_store.
//
//  channel | direction | signals                          | item
//  s       | in        | s_tvalid s_tready s_tdata        | character code
//  m       | out       | m_tvalid m_tready m_tdata/tuser  | LCD byte, tlast on final byte
//  cfg     | in        | cfg_valid cfg_ready cfg_index    | register write, always ready
//
// One shared index counter and one store read port produce one byte per cycle while m is
// not stalled.
// s_tready is high only while the sequencer is idle.
// A stall on m holds the sequencer. Reset fills the line store with spaces at once.
module char_lcd_scrolling_console_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] byte_value
    output logic       m_tuser,   // [0] is_command
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_NL_CLR, S_NL_HOME, S_NL_SET1, S_NL_SCROLL, S_NL_SET2, S_FF_DATA,
        S_CHAR, S_BS_CLR, S_BS_HOME, S_BS_SET1, S_BS_LINE1, S_BS_SET2, S_BS_LINE2,
        S_TAB, S_FLUSH
    } state_t;

    localparam logic [clcd_pkg::COL_W-1:0] LINE_END = clcd_pkg::COL_W'(clcd_pkg::LINE_LENGTH);

    state_t                     state_reg, state_next;
    logic [7:0]                 char_reg, char_next;
    logic [clcd_pkg::COL_W-1:0] column_reg, column_next;
    logic                       on_second_reg, on_second_next;
    logic [clcd_pkg::COL_W-1:0] idx_reg, idx_next;
    logic [6:0]                 first_addr_reg, second_addr_reg;
    logic [3:0]                 tab_reg;
    logic                       pend_valid_reg, pend_valid_next;
    logic                       pend_cmd_reg, pend_cmd_next;
    logic [7:0]                 pend_byte_reg, pend_byte_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_cmd_reg, out_cmd_next;
    logic [7:0]                 out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;

    logic                       adv;
    logic                       emit;
    logic                       emit_cmd;
    logic [7:0]                 emit_byte;
    logic                       finish;
    logic                       push;
    logic                       rd_line;
    logic [7:0]                 rd_data;
    clcd_pkg::store_wr_t        wr;
    logic [3:0]                 tab_lim;
    logic                       c_nl, c_ff, in_nl, in_ff;
    logic [clcd_pkg::COL_W-1:0] col_dec;

    clcd_line_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_line (rd_line),
        .rd_idx  (idx_reg[clcd_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign adv     = !out_valid_reg || m_tready;
    assign tab_lim = (tab_reg > clcd_pkg::TAB_MAX) ? clcd_pkg::TAB_MAX : tab_reg;
    assign c_nl    = (char_reg == clcd_pkg::CHAR_LF) || (char_reg == clcd_pkg::CHAR_CR);
    assign c_ff    = (char_reg == clcd_pkg::CHAR_FF);
    assign in_nl   = (s_tdata == clcd_pkg::CHAR_LF) || (s_tdata == clcd_pkg::CHAR_CR);
    assign in_ff   = (s_tdata == clcd_pkg::CHAR_FF);
    assign col_dec = column_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        char_next      = char_reg;
        column_next    = column_reg;
        on_second_next = on_second_reg;
        idx_next       = idx_reg;
        emit           = 1'b0;
        emit_cmd       = 1'b0;
        emit_byte      = 8'h00;
        finish         = 1'b0;
        rd_line        = 1'b0;
        wr             = '0;

        if (state_reg == S_IDLE)
        begin
            if (s_tvalid)
            begin
                char_next = s_tdata;
                if (column_reg == LINE_END || in_nl || in_ff)
                begin
                    state_next = on_second_reg ? S_NL_CLR : S_NL_SET2;
                end
                else
                begin
                    state_next = S_CHAR;
                end
            end
        end
        else if (adv)
        begin
            unique case (state_reg)
                S_NL_CLR, S_BS_CLR:
                begin
                    emit       = 1'b1;
                    emit_cmd   = 1'b1;
                    emit_byte  = clcd_pkg::CMD_CLEAR;
                    state_next = (state_reg == S_NL_CLR) ? S_NL_HOME : S_BS_HOME;
                end
                S_NL_HOME, S_BS_HOME:
                begin
                    emit       = 1'b1;
                    emit_cmd   = 1'b1;
                    emit_byte  = clcd_pkg::CMD_HOME;
                    state_next = (state_reg == S_NL_HOME) ? S_NL_SET1 : S_BS_SET1;
                end
                S_NL_SET1, S_BS_SET1:
                begin
                    emit       = 1'b1;
                    emit_cmd   = 1'b1;
                    emit_byte  = {clcd_pkg::CMD_SET_ADDR, first_addr_reg};
                    idx_next   = '0;
                    state_next = (state_reg == S_NL_SET1) ? S_NL_SCROLL : S_BS_LINE1;
                end
                S_NL_SCROLL:
                begin
                    rd_line = 1'b1;
                    if (idx_reg == LINE_END)
                    begin
                        state_next = S_NL_SET2;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_byte = rd_data;
                        wr.scroll = 1'b1;
                        wr.wr_idx = idx_reg[clcd_pkg::IDX_W-1:0];
                        idx_next  = idx_reg + 1'b1;
                    end
                end
                S_NL_SET2:
                begin
                    emit           = 1'b1;
                    emit_cmd       = 1'b1;
                    emit_byte      = {clcd_pkg::CMD_SET_ADDR, second_addr_reg};
                    on_second_next = 1'b1;
                    column_next    = c_ff ? column_reg : '0;
                    idx_next       = '0;
                    state_next     = c_ff ? S_FF_DATA : S_CHAR;
                end
                S_FF_DATA, S_BS_LINE2:
                begin
                    rd_line = 1'b1;
                    if (idx_reg == column_reg)
                    begin
                        state_next = (state_reg == S_FF_DATA) ? S_CHAR : S_FLUSH;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_byte = rd_data;
                        idx_next  = idx_reg + 1'b1;
                    end
                end
                S_CHAR:
                begin
                    idx_next = '0;
                    if (char_reg == clcd_pkg::CHAR_BS)
                    begin
                        if (column_reg != '0)
                        begin
                            column_next = col_dec;
                            wr.wr_en    = 1'b1;
                            wr.wr_line  = on_second_reg;
                            wr.wr_idx   = col_dec[clcd_pkg::IDX_W-1:0];
                            wr.wr_data  = clcd_pkg::SPACE_CHAR;
                            state_next  = S_BS_CLR;
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                    else if (c_nl || c_ff)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (char_reg == clcd_pkg::CHAR_HT)
                    begin
                        state_next = S_TAB;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_byte = char_reg;
                        if (column_reg != LINE_END)
                        begin
                            wr.wr_en    = 1'b1;
                            wr.wr_line  = on_second_reg;
                            wr.wr_idx   = column_reg[clcd_pkg::IDX_W-1:0];
                            wr.wr_data  = char_reg;
                            column_next = column_reg + 1'b1;
                        end
                        state_next = S_FLUSH;
                    end
                end
                S_BS_LINE1:
                begin
                    if (idx_reg == (on_second_reg ? LINE_END : column_reg))
                    begin
                        state_next = on_second_reg ? S_BS_SET2 : S_FLUSH;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_byte = rd_data;
                        idx_next  = idx_reg + 1'b1;
                    end
                end
                S_BS_SET2:
                begin
                    emit       = 1'b1;
                    emit_cmd   = 1'b1;
                    emit_byte  = {clcd_pkg::CMD_SET_ADDR, second_addr_reg};
                    idx_next   = '0;
                    state_next = S_BS_LINE2;
                end
                S_TAB:
                begin
                    if (idx_reg == clcd_pkg::COL_W'(tab_lim))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_byte = clcd_pkg::SPACE_CHAR;
                        idx_next  = idx_reg + 1'b1;
                    end
                end
                S_FLUSH:
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    // Hold one byte back so the final byte of a character can carry tlast.
    always_comb
    begin
        push            = adv && pend_valid_reg && (emit || finish);
        pend_valid_next = pend_valid_reg;
        pend_cmd_next   = pend_cmd_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_cmd_next    = out_cmd_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            pend_valid_next = 1'b1;
            pend_cmd_next   = emit_cmd;
            pend_byte_next  = emit_byte;
        end
        else if (finish)
        begin
            pend_valid_next = 1'b0;
        end
        if (push)
        begin
            out_valid_next = 1'b1;
            out_cmd_next   = pend_cmd_reg;
            out_byte_next  = pend_byte_reg;
            out_last_next  = finish;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            char_reg        <= '0;
            column_reg      <= '0;
            on_second_reg   <= 1'b0;
            idx_reg         <= '0;
            first_addr_reg  <= 7'd0;
            second_addr_reg <= 7'd64;
            tab_reg         <= 4'd4;
            pend_valid_reg  <= 1'b0;
            pend_cmd_reg    <= 1'b0;
            pend_byte_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_cmd_reg     <= 1'b0;
            out_byte_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            char_reg       <= char_next;
            column_reg     <= column_next;
            on_second_reg  <= on_second_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_cmd_reg   <= pend_cmd_next;
            pend_byte_reg  <= pend_byte_next;
            out_valid_reg  <= out_valid_next;
            out_cmd_reg    <= out_cmd_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            if (cfg_valid)
            begin
                if (cfg_index == clcd_pkg::CFG_FIRST_ADDR)
                begin
                    first_addr_reg <= cfg_data;
                end
                else if (cfg_index == clcd_pkg::CFG_SECOND_ADDR)
                begin
                    second_addr_reg <= cfg_data;
                end
                else if (cfg_index == clcd_pkg::CFG_TAB_WIDTH)
                begin
                    tab_reg <= cfg_data[3:0];
                end
            end
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign m_tuser   = out_cmd_reg;
    assign m_tlast   = out_last_reg;

endmodule

/* rtl/clcd_checker.sv */
// Port-level checks for the LCD console, attached to the top level by bind.
// Depends on clcd_pkg for command codes.
module clcd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // Drop ready in the cycle after taking an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready stayed high after an accepted item");

    // Hold the result while the consumer stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled output item changed");

    // Commands are clear, home or set address only.
    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == clcd_pkg::CMD_CLEAR
            || m_tdata == clcd_pkg::CMD_HOME || m_tdata[7]))
        else $error("illegal command byte");

endmodule

bind char_lcd_scrolling_console_unit clcd_checker u_clcd_checker (.*);

/* verif/testbench.sv */
// Testbench for the two-line character LCD scrolling console.
// Drives character items, predicts the LCD byte stream and checks it item by item.
// Depends on clcd_pkg and char_lcd_scrolling_console_unit.
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        bit         is_cmd;
        logic [7:0] value;
        bit         last;
    } lcd_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = clcd_pkg::CFG_FIRST_ADDR;
    logic [6:0] cfg_data = 7'd0;

    logic [7:0] pending_chars[$];
    lcd_byte_t  lcd_expected[$];
    int         chars_sent = 0;
    int         chars_accepted = 0;
    int         send_gap = 0;
    int         sink_gap = 0;
    int         mismatch_count = 0;
    bit         no_idle = 1'b0;
    bit         long_hold = 1'b0;

    logic [7:0] shadow[2*clcd_pkg::LINE_LENGTH];
    int         cur_col = 0;
    bit         on_line2 = 1'b0;
    logic [6:0] addr1 = 7'd0;
    logic [6:0] addr2 = 7'd64;
    logic [3:0] tab_w = 4'd4;

    char_lcd_scrolling_console_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0d: %s", mismatch_count, what);
    endfunction

    function automatic void push_byte(bit cmd, logic [7:0] v);
        lcd_byte_t e;
        e.is_cmd = cmd;
        e.value  = v;
        e.last   = 1'b0;
        lcd_expected.push_back(e);
    endfunction

    function automatic void push_set_addr(bit second);
        push_byte(1'b1, {clcd_pkg::CMD_SET_ADDR, second ? addr2 : addr1});
    endfunction

    function automatic void push_clear_home();
        push_byte(1'b1, clcd_pkg::CMD_CLEAR);
        push_byte(1'b1, clcd_pkg::CMD_HOME);
        push_set_addr(1'b0);
    endfunction

    function automatic void predict_lcd_bytes(logic [7:0] ch);
        bit is_nl;
        bit is_ff;
        int saved;
        int n;
        int base;
        int i;
        int start;
        start = lcd_expected.size();
        is_nl = (ch == clcd_pkg::CHAR_LF) || (ch == clcd_pkg::CHAR_CR);
        is_ff = (ch == clcd_pkg::CHAR_FF);
        if (cur_col >= clcd_pkg::LINE_LENGTH || is_nl || is_ff)
        begin
            saved = (cur_col > clcd_pkg::LINE_LENGTH) ? clcd_pkg::LINE_LENGTH : cur_col;
            cur_col = 0;
            if (on_line2)
            begin
                push_clear_home();
                for (i = 0; i < clcd_pkg::LINE_LENGTH; i++)
                begin
                    shadow[i] = shadow[clcd_pkg::LINE_LENGTH + i];
                    push_byte(1'b0, shadow[i]);
                    shadow[clcd_pkg::LINE_LENGTH + i] = clcd_pkg::SPACE_CHAR;
                end
            end
            on_line2 = 1'b1;
            push_set_addr(1'b1);
            if (is_ff)
            begin
                cur_col = saved;
                for (i = 0; i < saved; i++)
                    push_byte(1'b0, shadow[clcd_pkg::LINE_LENGTH + i]);
            end
        end
        if (ch == clcd_pkg::CHAR_BS)
        begin
            if (cur_col > 0)
            begin
                base = on_line2 ? clcd_pkg::LINE_LENGTH : 0;
                cur_col--;
                shadow[base + cur_col] = clcd_pkg::SPACE_CHAR;
                push_clear_home();
                n = on_line2 ? clcd_pkg::LINE_LENGTH : cur_col;
                for (i = 0; i < n; i++)
                    push_byte(1'b0, shadow[i]);
                if (on_line2)
                begin
                    push_set_addr(1'b1);
                    for (i = 0; i < cur_col; i++)
                        push_byte(1'b0, shadow[clcd_pkg::LINE_LENGTH + i]);
                end
            end
        end
        else if (ch == clcd_pkg::CHAR_HT)
        begin
            n = (tab_w > clcd_pkg::TAB_MAX) ? clcd_pkg::TAB_MAX : tab_w;
            for (i = 0; i < n; i++)
                push_byte(1'b0, clcd_pkg::SPACE_CHAR);
        end
        else if (!is_nl && !is_ff)
        begin
            base = on_line2 ? clcd_pkg::LINE_LENGTH : 0;
            push_byte(1'b0, ch);
            if (cur_col < clcd_pkg::LINE_LENGTH)
            begin
                shadow[base + cur_col] = ch;
                cur_col++;
            end
        end
        if (lcd_expected.size() > start)
            lcd_expected[$].last = 1'b1;
    endfunction

    // sender: hold the item until taken, then idle or offer the next one
    always @(negedge clk)
    begin
        if (s_tvalid && chars_sent != chars_accepted)
        begin
        end
        else if (send_gap > 0)
        begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_chars.size() > 0)
        begin
            s_tdata    <= pending_chars.pop_front();
            s_tvalid   <= 1'b1;
            chars_sent <= chars_sent + 1;
            send_gap   <= no_idle ? 0 : idle_len();
        end
        else
            s_tvalid <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            predict_lcd_bytes(s_tdata);
            chars_accepted <= chars_accepted + 1;
        end
    end

    // receiver: random stalls, plus one long hold-off
    always @(negedge clk)
    begin
        if (long_hold)
            m_tready <= 1'b0;
        else if (sink_gap > 0)
        begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            sink_gap <= idle_len();
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        lcd_byte_t e;
        if (m_tvalid && m_tready)
        begin
            if (lcd_expected.size() == 0)
                note_mismatch($sformatf("unexpected item cmd=%0b byte=%02h last=%0b",
                                        m_tuser, m_tdata, m_tlast));
            else
            begin
                e = lcd_expected.pop_front();
                if (m_tuser !== e.is_cmd || m_tdata !== e.value || m_tlast !== e.last)
                    note_mismatch($sformatf(
                        "expected cmd=%0b byte=%02h last=%0b, got cmd=%0b byte=%02h last=%0b",
                        e.is_cmd, e.value, e.last, m_tuser, m_tdata, m_tlast));
            end
        end
    end

    initial
    begin
        wait (chars_accepted >= 40);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (500) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            clcd_pkg::CFG_FIRST_ADDR:  addr1 = val;
            clcd_pkg::CFG_SECOND_ADDR: addr2 = val;
            clcd_pkg::CFG_TAB_WIDTH:   tab_w = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(logic [6:0] a1, logic [6:0] a2, logic [6:0] tab);
        write_reg(clcd_pkg::CFG_FIRST_ADDR, a1);
        write_reg(clcd_pkg::CFG_SECOND_ADDR, a2);
        write_reg(clcd_pkg::CFG_TAB_WIDTH, tab);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((pending_chars.size() != 0 || chars_sent != chars_accepted
                || lcd_expected.size() != 0) && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
    endtask

    function automatic void queue_random_text(int count);
        int k;
        int r;
        int burst;
        k = 0;
        while (k < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 68)
                pending_chars.push_back(8'($urandom_range(32, 126)));
            else if (r < 76)
                pending_chars.push_back(8'($urandom_range(0, 255)));
            else if (r < 83)
                pending_chars.push_back($urandom_range(0, 1) ? clcd_pkg::CHAR_LF
                                                             : clcd_pkg::CHAR_CR);
            else if (r < 88)
                pending_chars.push_back(clcd_pkg::CHAR_FF);
            else if (r < 95)
            begin
                burst = $urandom_range(1, 4);
                repeat (burst) pending_chars.push_back(clcd_pkg::CHAR_BS);
                k += burst - 1;
            end
            else
                pending_chars.push_back(clcd_pkg::CHAR_HT);
            k++;
        end
    endfunction

    initial
    begin
        int i;
        for (i = 0; i < 2 * clcd_pkg::LINE_LENGTH; i++)
            shadow[i] = clcd_pkg::SPACE_CHAR;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        apply_settings(7'd0, 7'd64, 7'd4);
        // backspace at column zero, tab, field extremes, line moves, scroll,
        // form feed redraw, then fill the line so the next one wraps
        pending_chars = '{clcd_pkg::CHAR_BS, clcd_pkg::CHAR_HT, 8'h00, 8'hFF,
                          clcd_pkg::CHAR_BS, clcd_pkg::CHAR_LF, 8'h78,
                          clcd_pkg::CHAR_BS, clcd_pkg::CHAR_CR, 8'h61, 8'h62,
                          clcd_pkg::CHAR_FF};
        for (i = 0; i < 14; i++)
            pending_chars.push_back(8'h41 + 8'(i));
        pending_chars.push_back(8'h7E);
        wait_drained();

        apply_settings(7'd127, 7'd0, 7'd0);
        queue_random_text(26);
        wait_drained();

        apply_settings(7'd0, 7'd127, 7'h7F);
        queue_random_text(26);
        wait_drained();

        apply_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)));
        queue_random_text(26);
        wait_drained();

        no_idle = 1'b1;
        apply_settings(7'h2A, 7'h55, 7'd8);
        queue_random_text(26);
        wait_drained();

        no_idle = 1'b0;
        apply_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 15)));
        queue_random_text(26);
        wait_drained();

        if (lcd_expected.size() != 0)
            note_mismatch($sformatf("%0d expected items never arrived", lcd_expected.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
